@@ rtl/core/ddn_pkg.sv @@
package ddn_pkg;

	localparam int unsigned DayW    = 5;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned YearW   = 14;
	localparam int unsigned NumW    = 22;
	localparam int unsigned DiffW   = 23;

	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;
	localparam logic [YearW-1:0]  YearMax  = 14'd9999;
	localparam logic [DayW-1:0]   DayLeap  = 5'd29;
	localparam logic [DayW-1:0]   DayFebEnd = 5'd28;

	// floor(x / 25) = (x * Recip25) >> Recip25Shift for x below 4096
	localparam logic [12:0] Recip25      = 13'd5243;
	localparam int unsigned Recip25Shift = 17;

	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
	} date_t;

	typedef struct packed {
		logic            valid;
		logic [NumW-1:0] number;
	} day_num_t;

	function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m);
		logic [DayW-1:0] r;
		unique case (m)
			4'd2:                   r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/ddn_if.sv @@
interface ddn_in_if;
	logic                         valid;
	logic                         ready;
	logic [ddn_pkg::DayW-1:0]     first_day;
	logic [ddn_pkg::MonthW-1:0]   first_month;
	logic [ddn_pkg::YearW-1:0]    first_year;
	logic [ddn_pkg::DayW-1:0]     second_day;
	logic [ddn_pkg::MonthW-1:0]   second_month;
	logic [ddn_pkg::YearW-1:0]    second_year;

	modport source(output valid, first_day, first_month, first_year,
		second_day, second_month, second_year, input ready);
	modport sink(input valid, first_day, first_month, first_year,
		second_day, second_month, second_year, output ready);
endinterface

interface ddn_out_if;
	logic                         valid;
	logic                         ready;
	logic                         first_valid;
	logic                         second_valid;
	logic [ddn_pkg::NumW-1:0]     first_day_number;
	logic [ddn_pkg::DiffW-1:0]    day_difference;

	modport source(output valid, first_valid, second_valid, first_day_number,
		day_difference, input ready);
	modport sink(input valid, first_valid, second_valid, first_day_number,
		day_difference, output ready);
endinterface

@@ rtl/core/ddn_date_conv.sv @@
module ddn_date_conv (
	input  ddn_pkg::date_t    date,
	output ddn_pkg::day_num_t result
);

	logic [11:0] y4;
	logic [24:0] y_prod;
	logic [7:0]  y_q;
	logic [11:0] y_rem;
	logic        div4;
	logic        div100;
	logic        div400;
	logic        leap;
	logic [4:0]  day_adj;
	logic        range_ok;
	logic [4:0]  len;
	logic        ok;
	logic [13:0] p;
	logic [11:0] p4;
	logic [24:0] p_prod;
	logic [7:0]  q100;
	logic [5:0]  q400;
	logic        after_feb;
	logic [22:0] total;

	// leap test: y/100 = (y/4)/25, remainder checked against zero
	assign y4     = date.year[13:2];
	assign y_prod = 25'(y4) * 25'(ddn_pkg::Recip25);
	assign y_q    = y_prod[24:ddn_pkg::Recip25Shift];
	assign y_rem  = y4 - 12'(y_q * 12'd25);
	assign div4   = (date.year[1:0] == 2'd0);
	assign div100 = div4 && (y_rem == 12'd0);
	assign div400 = div100 && (y_q[1:0] == 2'd0);
	assign leap   = div400 || (div4 && !div100);

	// clamp 29 February of a common year
	assign day_adj = (date.day == ddn_pkg::DayLeap && date.month == ddn_pkg::MonthFeb && !leap)
		? ddn_pkg::DayFebEnd : date.day;

	assign range_ok = (day_adj != 5'd0) && (date.month >= ddn_pkg::MonthJan)
		&& (date.month <= ddn_pkg::MonthDec) && (date.year != 14'd0)
		&& (date.year <= ddn_pkg::YearMax);
	assign len = ddn_pkg::month_length(date.month)
		+ 5'((date.month == ddn_pkg::MonthFeb) && leap);
	assign ok  = range_ok && (day_adj <= len);

	assign p      = date.year - 14'd1;
	assign p4     = p[13:2];
	assign p_prod = 25'(p4) * 25'(ddn_pkg::Recip25);
	assign q100   = p_prod[24:ddn_pkg::Recip25Shift];
	assign q400   = q100[7:2];
	assign after_feb = leap && (date.month > ddn_pkg::MonthFeb);

	assign total = 23'(p) * 23'd365 + 23'(p4) - 23'(q100) + 23'(q400)
		+ 23'(ddn_pkg::days_before_month(date.month)) + 23'(after_feb)
		+ 23'(day_adj) - 23'd1;

	assign result.valid  = ok;
	assign result.number = ok ? total[ddn_pkg::NumW-1:0] : '0;

endmodule

@@ rtl/core/date_day_number_difference_top.sv @@
// An accepted word passes the input register, then the result register, into its result word.
// Throughput: one date pair per cycle when not stalled; converters work in parallel in one stage.
// A stalled output holds the pipeline; the input stays ready while a stage can move on.
// Reset (arst_n low, asynchronous) empties both stages; payload registers are not reset.
module date_day_number_difference_top (
	input  logic        clk,
	input  logic        arst_n,
	ddn_in_if.sink      dates,
	ddn_out_if.source   numbers
);

	logic              v_s1;
	ddn_pkg::date_t    first_s1;
	ddn_pkg::date_t    second_s1;
	ddn_pkg::day_num_t first_res;
	ddn_pkg::day_num_t second_res;
	logic [ddn_pkg::DiffW-1:0] diff;
	logic              v_s2;
	logic              first_valid_s2;
	logic              second_valid_s2;
	logic [ddn_pkg::NumW-1:0]  first_num_s2;
	logic [ddn_pkg::DiffW-1:0] diff_s2;
	logic              adv_s2;
	logic              adv_s1;

	assign adv_s2 = !v_s2 || numbers.ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign dates.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= dates.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && dates.valid) begin
			first_s1  <= '{day: dates.first_day, month: dates.first_month,
				year: dates.first_year};
			second_s1 <= '{day: dates.second_day, month: dates.second_month,
				year: dates.second_year};
		end
	end

	ddn_date_conv u_conv_first (
		.date   (first_s1),
		.result (first_res)
	);

	ddn_date_conv u_conv_second (
		.date   (second_s1),
		.result (second_res)
	);

	assign diff = ddn_pkg::DiffW'(second_res.number) - ddn_pkg::DiffW'(first_res.number);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			first_valid_s2  <= first_res.valid;
			second_valid_s2 <= second_res.valid;
			first_num_s2    <= first_res.number;
			diff_s2         <= diff;
		end
	end

	assign numbers.valid            = v_s2;
	assign numbers.first_valid      = first_valid_s2;
	assign numbers.second_valid     = second_valid_s2;
	assign numbers.first_day_number = first_num_s2;
	assign numbers.day_difference   = diff_s2;

	a_invalid_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		numbers.valid && !numbers.first_valid |-> numbers.first_day_number == '0)
		else $error("invalid first date gave a non-zero day number");

	a_both_invalid_no_diff: assert property (@(posedge clk) disable iff (!arst_n)
		numbers.valid && !numbers.first_valid && !numbers.second_valid
		|-> numbers.day_difference == '0)
		else $error("two invalid dates gave a non-zero difference");

	a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !numbers.ready |-> !dates.ready)
		else $error("input taken while both stages are held");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		dates.valid && dates.ready |=> v_s1)
		else $error("accepted word did not reach the input stage");

endmodule

@@ bench/date_day_number_difference_top_test.sv @@
module date_day_number_difference_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                      first_valid;
		logic                      second_valid;
		logic [ddn_pkg::NumW-1:0]  first_day_number;
		logic [ddn_pkg::DiffW-1:0] day_difference;
	} day_gap_t;

	typedef struct {
		ddn_pkg::date_t first;
		ddn_pkg::date_t second;
		bit             typed;
		day_gap_t       want;
	} pair_row_t;

	logic clk;
	logic arst_n;

	ddn_in_if  dates();
	ddn_out_if numbers();

	date_day_number_difference_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.dates   (dates),
		.numbers (numbers)
	);

	day_gap_t    gaps_due[$];
	pair_row_t   date_plan[$];
	int unsigned mismatches;
	int unsigned words_out;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned month_span(input int unsigned m, input bit leap);
		if (m == 32'(ddn_pkg::MonthFeb))
			return leap ? 29 : 28;
		return 30 + ((m + m / 8) % 2);
	endfunction

	// Days from 0001-01-01; invalid dates count as day 0 with the flag low.
	function automatic ddn_pkg::day_num_t day_count(input ddn_pkg::date_t dt);
		ddn_pkg::day_num_t r;
		int unsigned       d, m, y, p, k, n;
		bit                leap;
		d = 32'(dt.day);
		m = 32'(dt.month);
		y = 32'(dt.year);
		leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
		r = '0;
		// clamp 29 Feb of a common year before any check
		if (d == 32'(ddn_pkg::DayLeap) && m == 32'(ddn_pkg::MonthFeb) && !leap)
			d = 32'(ddn_pkg::DayFebEnd);
		if (d == 0 || m < 32'(ddn_pkg::MonthJan) || m > 32'(ddn_pkg::MonthDec) || y == 0
				|| y > 32'(ddn_pkg::YearMax))
			return r;
		if (d > month_span(m, leap))
			return r;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400 + d - 1;
		for (k = 32'(ddn_pkg::MonthJan); k < m; k++)
			n += month_span(k, leap);
		r.number = ddn_pkg::NumW'(n);
		r.valid  = 1'b1;
		return r;
	endfunction

	function automatic day_gap_t span_of(input ddn_pkg::date_t f, input ddn_pkg::date_t s);
		ddn_pkg::day_num_t a, b;
		day_gap_t          g;
		a = day_count(f);
		b = day_count(s);
		g.first_valid      = a.valid;
		g.second_valid     = b.valid;
		g.first_day_number = a.number;
		g.day_difference   = {1'b0, b.number} - {1'b0, a.number};
		return g;
	endfunction

	function automatic ddn_pkg::date_t cal(input int unsigned d, input int unsigned m,
			input int unsigned y);
		ddn_pkg::date_t r;
		r.day   = ddn_pkg::DayW'(d);
		r.month = ddn_pkg::MonthW'(m);
		r.year  = ddn_pkg::YearW'(y);
		return r;
	endfunction

	function automatic void plan_typed(input ddn_pkg::date_t f, input ddn_pkg::date_t s,
			input bit fv, input bit sv, input int num, input int diff);
		pair_row_t r;
		r.first  = f;
		r.second = s;
		r.typed  = 1'b1;
		r.want.first_valid      = fv;
		r.want.second_valid     = sv;
		r.want.first_day_number = ddn_pkg::NumW'(num);
		r.want.day_difference   = ddn_pkg::DiffW'(diff);
		date_plan.push_back(r);
	endfunction

	function automatic void plan_pred(input ddn_pkg::date_t f, input ddn_pkg::date_t s);
		pair_row_t r;
		r.first  = f;
		r.second = s;
		r.typed  = 1'b0;
		r.want   = '0;
		date_plan.push_back(r);
	endfunction

	// Mostly plausible dates, with February, edge years, nearby years and raw bits mixed in.
	function automatic ddn_pkg::date_t pick_date(input ddn_pkg::date_t near);
		ddn_pkg::date_t r;
		int unsigned    kind;
		kind = $urandom_range(99);
		r.day   = ddn_pkg::DayW'($urandom_range(1, 31));
		r.month = ddn_pkg::MonthW'($urandom_range(1, 12));
		r.year  = ddn_pkg::YearW'($urandom_range(1, 9999));
		if (kind < 10) begin
			r.day   = ddn_pkg::DayW'($urandom);
			r.month = ddn_pkg::MonthW'($urandom);
			r.year  = ddn_pkg::YearW'($urandom);
		end else if (kind < 20) begin
			case ($urandom_range(3))
				0:       r.year = '0;
				1:       r.year = ddn_pkg::YearW'(1);
				2:       r.year = ddn_pkg::YearMax;
				default: r.year = ddn_pkg::YearW'(32'(ddn_pkg::YearMax) + 1);
			endcase
		end else if (kind < 35) begin
			r.month = ddn_pkg::MonthFeb;
			r.day   = ddn_pkg::DayW'($urandom_range(27, 30));
			r.year  = ddn_pkg::YearW'($urandom_range(1) ? $urandom_range(0, 100) * 100
				: $urandom_range(0, 10010));
		end else if (kind < 55) begin
			r.year = ddn_pkg::YearW'(32'(near.year) + $urandom_range(2) - 1);
		end
		return r;
	endfunction

	task automatic offer_pair(input pair_row_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			dates.valid <= 1'b0;
			@(posedge clk);
		end
		dates.valid        <= 1'b1;
		dates.first_day    <= r.first.day;
		dates.first_month  <= r.first.month;
		dates.first_year   <= r.first.year;
		dates.second_day   <= r.second.day;
		dates.second_month <= r.second.month;
		dates.second_year  <= r.second.year;
		@(posedge clk);
		while (!dates.ready)
			@(posedge clk);
		gaps_due.push_back(r.typed ? r.want : span_of(r.first, r.second));
	endtask

	// Receiver: random back-pressure plus a long hold every few hundred words.
	initial begin : drain
		int unsigned hold_left;
		int unsigned next_hold;
		hold_left = 0;
		next_hold = 300;
		numbers.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				numbers.ready <= 1'b0;
				hold_left--;
			end else if (words_out >= next_hold) begin
				numbers.ready <= 1'b0;
				hold_left = 47;
				next_hold += 600;
			end else begin
				numbers.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_numbers
		day_gap_t want;
		day_gap_t got;
		if (arst_n && numbers.valid && numbers.ready) begin
			words_out++;
			got.first_valid      = numbers.first_valid;
			got.second_valid     = numbers.second_valid;
			got.first_day_number = numbers.first_day_number;
			got.day_difference   = numbers.day_difference;
			if (gaps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: valid %b/%b number %0d diff %0d",
						got.first_valid, got.second_valid, got.first_day_number,
						$signed(got.day_difference));
			end else begin
				want = gaps_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: expected valid %b/%b number %0d diff %0d, got %b/%b %0d %0d",
							words_out, want.first_valid, want.second_valid,
							want.first_day_number, $signed(want.day_difference),
							got.first_valid, got.second_valid, got.first_day_number,
							$signed(got.day_difference));
				end
			end
		end
	end

	initial begin : stimulus
		pair_row_t      r;
		ddn_pkg::date_t prev;
		int unsigned    k;
		mismatches   = 0;
		words_out    = 0;
		tx_idle_pct  = 32;
		rx_idle_pct  = 87;
		arst_n       = 1'b0;
		dates.valid        = 1'b0;
		dates.first_day    = '0;
		dates.first_month  = '0;
		dates.first_year   = '0;
		dates.second_day   = '0;
		dates.second_month = '0;
		dates.second_year  = '0;

		plan_typed(cal(1, 1, 1), cal(1, 1, 1), 1, 1, 0, 0);
		plan_typed(cal(0, 0, 0), cal(0, 0, 0), 0, 0, 0, 0);
		plan_typed(cal(31, 12, 9999), cal(1, 1, 1), 1, 1, 3652058, -3652058);
		plan_typed(cal(1, 1, 1), cal(31, 12, 9999), 1, 1, 0, 3652058);
		plan_typed(cal(31, 15, 16383), cal(31, 15, 16383), 0, 0, 0, 0);
		plan_typed(cal(0, 1, 2000), cal(1, 0, 2000), 0, 0, 0, 0);
		plan_typed(cal(1, 13, 2000), cal(1, 1, 10000), 0, 0, 0, 0);
		plan_typed(cal(1, 1, 0), cal(31, 12, 9999), 0, 1, 0, 3652058);
		// 29 February in common, century and leap years, then other month ends and range edges
		plan_pred(cal(29, 2, 2023), cal(28, 2, 2023));
		plan_pred(cal(29, 2, 2024), cal(1, 3, 2024));
		plan_pred(cal(29, 2, 1900), cal(29, 2, 2000));
		plan_pred(cal(30, 2, 2024), cal(29, 2, 2100));
		plan_pred(cal(29, 2, 0), cal(29, 2, 10001));
		plan_pred(cal(31, 4, 2021), cal(30, 4, 2021));
		plan_pred(cal(31, 12, 2000), cal(1, 1, 2001));
		plan_pred(cal(1, 3, 1600), cal(28, 2, 1600));
		plan_pred(cal(31, 1, 9999), cal(1, 1, 1));
		plan_pred(cal(15, 6, 1970), cal(4, 7, 1776));
		plan_pred(cal(31, 6, 2022), cal(31, 11, 2022));
		plan_pred(cal(30, 9, 9999), cal(1, 10, 1));
		plan_pred(cal(16, 8, 5123), cal(22, 3, 8191));
		plan_pred(cal(31, 12, 16383), cal(1, 1, 8192));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (date_plan[i])
			offer_pair(date_plan[i]);

		prev = cal(1, 1, 2000);
		for (k = 0; k < 1880; k++) begin
			if (k == 620) begin
				tx_idle_pct = 87;
				rx_idle_pct = 32;
			end else if (k == 1250) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			r.typed  = 1'b0;
			r.want   = '0;
			r.first  = pick_date(prev);
			r.second = pick_date(r.first);
			prev     = r.second;
			offer_pair(r);
		end
		dates.valid <= 1'b0;

		while (gaps_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0 && gaps_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
